// File: rtl/puc_pkg.sv
package puc_pkg;

  // Field widths
  localparam int unsigned CoefW   = 16;
  localparam int unsigned RawW    = 10;
  localparam int unsigned UnwrapW = 11;
  localparam int unsigned OutW    = 20;
  localparam int unsigned ActW    = 2;
  localparam int unsigned IdxW    = 2;

  // Datapath widths
  localparam int unsigned MulAW   = 26;
  localparam int unsigned MulBW   = 12;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AccW    = 40;
  localparam int unsigned FracSh  = 18;

  // Wrap span of the raw pressure counter
  localparam logic [RawW-1:0] WrapSpan = 10'd1023;

  // Action codes
  localparam logic [ActW-1:0] ACT_MEASURE   = 2'd0;
  localparam logic [ActW-1:0] ACT_CALIBRATE = 2'd1;
  localparam logic [ActW-1:0] ACT_LOAD_LAST = 2'd2;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_A0  = 2'd0;
  localparam logic [IdxW-1:0] REG_B1  = 2'd1;
  localparam logic [IdxW-1:0] REG_B2  = 2'd2;
  localparam logic [IdxW-1:0] REG_C12 = 2'd3;

  // Controller to datapath commands, one step each
  typedef struct packed {
    logic accept;
    logic mul_ct;
    logic mul_bt;
    logic mul_kp;
    logic acc_kp;
    logic finish;
  } puc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic arith;
  } puc_stat_t;

endpackage

// File: rtl/puc_ctrl.sv
module puc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  puc_pkg::puc_stat_t stat,
  output puc_pkg::puc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CT   = 3'd1;
  localparam logic [2:0] S_BT   = 3'd2;
  localparam logic [2:0] S_KP   = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // Hold off the sender while busy and while in reset
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

  // Sequence one word through the shared multiplier
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.arith ? S_CT : S_FIN;
        end
      end
      S_CT: begin
        cmd.mul_ct = 1'b1;
        state_nxt  = S_BT;
      end
      S_BT: begin
        cmd.mul_bt = 1'b1;
        state_nxt  = S_KP;
      end
      S_KP: begin
        cmd.mul_kp = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_kp = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result word until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_arith_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.arith) |=> state_r == S_CT)
    else $error("arithmetic word did not start the multiply sequence");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result overwritten while receiver stalls");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result word raised outside finish step");

  a_kp_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KP |-> $past(state_r) == S_BT)
    else $error("multiply steps out of order");

endmodule

// File: rtl/puc_dpath.sv
module puc_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  puc_pkg::puc_cmd_t                   cmd,
  output puc_pkg::puc_stat_t                  stat,
  input  logic                                cfg_valid,
  input  logic [puc_pkg::IdxW-1:0]            cfg_index,
  input  logic [puc_pkg::CoefW-1:0]           cfg_wdata,
  input  logic [puc_pkg::ActW-1:0]            in_action,
  input  logic [puc_pkg::RawW-1:0]            in_raw_pressure,
  input  logic [puc_pkg::RawW-1:0]            in_raw_temperature,
  output logic signed [puc_pkg::OutW-1:0]     out_pressure_out,
  output logic                                out_offset_applied
);

  // Coefficients
  logic signed [puc_pkg::CoefW-1:0] a0_r, b1_r, b2_r, c12_r;

  // Item state
  logic signed [puc_pkg::UnwrapW-1:0] last_r;
  logic signed [puc_pkg::UnwrapW-1:0] p_r;
  logic [puc_pkg::RawW-1:0]           t_r;
  logic [puc_pkg::ActW-1:0]           act_r;
  logic                               off_valid_r;
  logic signed [puc_pkg::OutW-1:0]    zero_off_r;

  // Arithmetic registers
  logic signed [puc_pkg::ProdW-1:0]   prod_r;
  logic signed [puc_pkg::MulAW-1:0]   k_r;
  logic signed [puc_pkg::AccW-1:0]    acc_r;
  logic signed [puc_pkg::OutW-1:0]    res_r;
  logic                               applied_r;

  // Unwrap and multiplier signals
  logic signed [12:0]                 cand_hi, cand_lo, d_hi, d_lo, mag_hi, mag_lo;
  logic signed [puc_pkg::UnwrapW-1:0] p_unw;
  logic signed [puc_pkg::MulAW-1:0]   mul_a;
  logic signed [puc_pkg::MulBW-1:0]   mul_b;
  logic signed [puc_pkg::ProdW-1:0]   mul_p;
  logic signed [puc_pkg::MulAW-1:0]   c_ext;
  logic signed [puc_pkg::OutW-1:0]    value;

  assign stat.arith = (in_action == puc_pkg::ACT_MEASURE) ||
                      (in_action == puc_pkg::ACT_CALIBRATE);

  // Pick raw or raw minus span, whichever lies nearer the last value
  always_comb begin
    cand_hi = $signed({3'b000, in_raw_pressure});
    cand_lo = cand_hi - $signed({3'b000, puc_pkg::WrapSpan});
    d_hi    = {{2{last_r[puc_pkg::UnwrapW-1]}}, last_r} - cand_hi;
    d_lo    = {{2{last_r[puc_pkg::UnwrapW-1]}}, last_r} - cand_lo;
    mag_hi  = d_hi[12] ? -d_hi : d_hi;
    mag_lo  = d_lo[12] ? -d_lo : d_lo;
    p_unw   = (mag_hi < mag_lo) ? cand_hi[puc_pkg::UnwrapW-1:0]
                                : cand_lo[puc_pkg::UnwrapW-1:0];
  end

  // Shared multiplier operand select
  assign c_ext = {{12{c12_r[puc_pkg::CoefW-1]}}, c12_r[puc_pkg::CoefW-1:2]};

  always_comb begin
    mul_a = c_ext;
    mul_b = $signed({2'b00, t_r});
    if (cmd.mul_bt) begin
      mul_a = {{10{b2_r[puc_pkg::CoefW-1]}}, b2_r};
    end else if (cmd.mul_kp) begin
      mul_a = k_r;
      mul_b = {p_r[puc_pkg::UnwrapW-1], p_r};
    end
  end

  assign mul_p = mul_a * mul_b;
  assign value = acc_r[puc_pkg::FracSh +: puc_pkg::OutW];

  // Write coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r  <= '0;
      b1_r  <= '0;
      b2_r  <= '0;
      c12_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        puc_pkg::REG_A0:  a0_r  <= cfg_wdata;
        puc_pkg::REG_B1:  b1_r  <= cfg_wdata;
        puc_pkg::REG_B2:  b2_r  <= cfg_wdata;
        puc_pkg::REG_C12: c12_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Track last pressure and the zero offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      off_valid_r <= 1'b0;
      zero_off_r  <= '0;
    end else begin
      if (cmd.accept) begin
        if (stat.arith) begin
          last_r <= p_unw;
        end else if (in_action == puc_pkg::ACT_LOAD_LAST) begin
          last_r <= $signed({1'b0, in_raw_pressure});
        end
      end
      if (cmd.finish && act_r == puc_pkg::ACT_CALIBRATE) begin
        off_valid_r <= 1'b1;
        zero_off_r  <= value;
      end
    end
  end

  // Latch the word, then step the sum a0 + (b1 + c*T)*P + b2*T
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r   <= p_unw;
      t_r   <= in_raw_temperature;
      act_r <= in_action;
    end
    if (cmd.mul_ct) begin
      prod_r <= mul_p;
      acc_r  <= {{5{a0_r[puc_pkg::CoefW-1]}}, a0_r, 19'b0};
    end
    if (cmd.mul_bt) begin
      prod_r <= mul_p;
      k_r    <= {b1_r[puc_pkg::CoefW-1], b1_r, 9'b0} + prod_r[puc_pkg::MulAW-1:0];
    end
    if (cmd.mul_kp) begin
      prod_r <= mul_p;
      acc_r  <= acc_r + {prod_r[31:0], 8'b0};
    end
    if (cmd.acc_kp) begin
      acc_r <= acc_r + {{(puc_pkg::AccW-puc_pkg::ProdW){prod_r[puc_pkg::ProdW-1]}}, prod_r};
    end
    if (cmd.finish) begin
      res_r     <= '0;
      applied_r <= 1'b0;
      if (act_r == puc_pkg::ACT_MEASURE) begin
        res_r     <= off_valid_r ? value - zero_off_r : value;
        applied_r <= off_valid_r;
      end else if (act_r == puc_pkg::ACT_CALIBRATE) begin
        res_r <= value;
      end
    end
  end

  assign out_pressure_out   = res_r;
  assign out_offset_applied = applied_r;

endmodule

// File: rtl/pressure_unwrap_compensate.sv
// Barometer pressure unwrap and temperature compensation.
//
// Input channel (in_valid / in_stall): one word carries an action, a raw
// 10-bit pressure and a raw 10-bit temperature. Measure and calibrate words
// unwrap the pressure against the last value, evaluate
// a0 + (b1 + c12*T)*P + b2*T on one shared multiplier and return the
// result in 1/16 count. Calibrate stores it as the zero offset; measure
// subtracts that offset once one is stored. Load-last and the unused code
// return a zero word.
// Output channel (out_valid / out_stall): one result word per input word,
// held in an output register until taken.
// Config channel (cfg_valid / cfg_ready, ready whenever out of reset): writes
// coefficients a0, b1, b2, c12 at indexes 0..3; write only while no word is
// in flight.
// Measure and calibrate words step through the multiply sequence CT, BT,
// KP, ACC, FIN; other words go straight to FIN. A new word is taken only
// once the block is back in idle after FIN.
// A stalled output word holds the block in its finish step.
// Reset (rst_n low, synchronous) clears coefficients, last pressure,
// the zero offset and all handshake state; no word is taken during reset.
module pressure_unwrap_compensate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [puc_pkg::ActW-1:0]        in_action,
  input  logic [puc_pkg::RawW-1:0]        in_raw_pressure,
  input  logic [puc_pkg::RawW-1:0]        in_raw_temperature,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [puc_pkg::OutW-1:0] out_pressure_out,
  output logic                            out_offset_applied,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [puc_pkg::IdxW-1:0]        cfg_index,
  input  logic [puc_pkg::CoefW-1:0]       cfg_wdata
);

  puc_pkg::puc_cmd_t  cmd;
  puc_pkg::puc_stat_t stat;

  assign cfg_ready = rst_n;

  puc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  puc_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_pressure_out   (out_pressure_out),
    .out_offset_applied (out_offset_applied)
  );

endmodule

// File: tb/pressure_unwrap_compensate_tb.sv
module pressure_unwrap_compensate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf    = 5;
  localparam int unsigned ResetLen   = 9;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned SqueezeLen = 300;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseWords = 240;
  localparam logic [puc_pkg::ActW-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [puc_pkg::ActW-1:0] action;
    logic [puc_pkg::RawW-1:0] raw_p;
    logic [puc_pkg::RawW-1:0] raw_t;
  } word_t;

  typedef struct packed {
    logic signed [puc_pkg::OutW-1:0] pressure;
    logic                            applied;
  } reading_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [puc_pkg::ActW-1:0]        in_action = '0;
  logic [puc_pkg::RawW-1:0]        in_raw_pressure = '0;
  logic [puc_pkg::RawW-1:0]        in_raw_temperature = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [puc_pkg::OutW-1:0] out_pressure_out;
  logic                            out_offset_applied;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [puc_pkg::IdxW-1:0]        cfg_index = '0;
  logic [puc_pkg::CoefW-1:0]       cfg_wdata = '0;

  pressure_unwrap_compensate dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pressure_out   (out_pressure_out),
    .out_offset_applied (out_offset_applied),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #(ClkHalf) clk = ~clk;

  // Predictor copy of coefficients and sensor state
  logic signed [puc_pkg::CoefW-1:0]   k_a0 = '0, k_b1 = '0, k_b2 = '0, k_c12 = '0;
  logic signed [puc_pkg::UnwrapW-1:0] last_unw = '0;
  logic                               offset_held = 1'b0;
  logic signed [puc_pkg::OutW-1:0]    zero_off = '0;

  word_t    pending_words[$];
  reading_t expected_readings[$];
  word_t    offered = '0;

  int words_planned = 0;
  int words_in = 0;
  int words_out = 0;
  int calibrations = 0;
  int corrected = 0;
  int mismatches = 0;

  // Unwrap the pressure, evaluate the polynomial and apply or capture the offset; load-last sets the last value
  function automatic reading_t compensate_word(word_t w);
    reading_t r;
    longint   p_hi, p_lo, last, p, t, c, acc, val, d_hi, d_lo;
    r = '0;
    if (w.action == puc_pkg::ACT_MEASURE || w.action == puc_pkg::ACT_CALIBRATE) begin
      last = longint'(last_unw);
      p_hi = longint'(w.raw_p);
      p_lo = p_hi - 1023;
      d_hi = (last > p_hi) ? last - p_hi : p_hi - last;
      d_lo = (last > p_lo) ? last - p_lo : p_lo - last;
      p = (d_hi < d_lo) ? p_hi : p_lo;
      last_unw = p[puc_pkg::UnwrapW-1:0];
      t = longint'(w.raw_t);
      c = longint'(k_c12) >>> 2;
      acc = longint'(k_a0) * 524288 + longint'(k_b1) * p * 512 + c * t * p
          + longint'(k_b2) * t * 256;
      val = acc >>> puc_pkg::FracSh;
      if (w.action == puc_pkg::ACT_CALIBRATE) begin
        zero_off = val[puc_pkg::OutW-1:0];
        offset_held = 1'b1;
        calibrations++;
      end else if (offset_held) begin
        val = val - longint'(zero_off);
        r.applied = 1'b1;
        corrected++;
      end
      r.pressure = val[puc_pkg::OutW-1:0];
    end else if (w.action == puc_pkg::ACT_LOAD_LAST) begin
      last_unw = {1'b0, w.raw_p};
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    logic  nv;
    word_t nxt;
    nv = in_valid;
    nxt = offered;
    if (rst_n && in_valid && !in_stall) begin
      expected_readings.push_back(compensate_word(offered));
      words_in++;
      nv = 1'b0;
    end
    if (rst_n && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        nxt = pending_words.pop_front();
        nv = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_valid <= nv;
    offered <= nxt;
    in_action <= nxt.action;
    in_raw_pressure <= nxt.raw_p;
    in_raw_temperature <= nxt.raw_t;
  end

  // Receiver: stall pattern in changing modes, plus two long hold-offs
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int squeeze_left = 0;
  int squeezes = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(30, 200);
    end else begin
      mode_left--;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else if (squeezes < 2 && words_in >= 700 + 800 * squeezes) begin
      squeezes++;
      squeeze_left = SqueezeLen;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("unexpected word pressure=%0d applied=%0b",
                                out_pressure_out, out_offset_applied));
      end else begin
        want = expected_readings.pop_front();
        if (out_pressure_out !== want.pressure)
          flag_mismatch($sformatf("word %0d pressure_out exp %0d got %0d",
                                  words_out, want.pressure, out_pressure_out));
        if (out_offset_applied !== want.applied)
          flag_mismatch($sformatf("word %0d offset_applied exp %0b got %0b",
                                  words_out, want.applied, out_offset_applied));
      end
    end
  end

  // Watchdog: end the run when no handshake completes for too long
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d words still expected",
               quiet, expected_readings.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_coef(input logic [puc_pkg::IdxW-1:0] idx,
                            input logic [puc_pkg::CoefW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      puc_pkg::REG_A0:  k_a0 = val;
      puc_pkg::REG_B1:  k_b1 = val;
      puc_pkg::REG_B2:  k_b2 = val;
      default:          k_c12 = val;
    endcase
  endtask

  task automatic write_all(input logic [puc_pkg::CoefW-1:0] a0,
                           input logic [puc_pkg::CoefW-1:0] b1,
                           input logic [puc_pkg::CoefW-1:0] b2,
                           input logic [puc_pkg::CoefW-1:0] c12);
    write_coef(puc_pkg::REG_A0, a0);
    write_coef(puc_pkg::REG_B1, b1);
    write_coef(puc_pkg::REG_B2, b2);
    write_coef(puc_pkg::REG_C12, c12);
  endtask

  task automatic queue_word(input logic [puc_pkg::ActW-1:0] act, input int p, input int t);
    word_t w;
    w.action = act;
    w.raw_p = p[puc_pkg::RawW-1:0];
    w.raw_t = t[puc_pkg::RawW-1:0];
    pending_words.push_back(w);
    words_planned++;
  endtask

  // Hold until every queued word is accepted and answered
  task automatic drain();
    while (words_in != words_planned || expected_readings.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  initial begin
    int walk;
    int r;
    int act;
    int rp;
    int rt;
    walk = 0;
    repeat (ResetLen) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unwrap edges, offset handling, load-last and the unused code
    write_all(16'sd1000, -16'sd12000, 16'sd3000, -16'sd4001);
    queue_word(puc_pkg::ACT_MEASURE, 0, 0);
    queue_word(puc_pkg::ACT_MEASURE, 1023, 1023);
    queue_word(puc_pkg::ACT_MEASURE, 512, 0);
    queue_word(puc_pkg::ACT_MEASURE, 511, 1023);
    queue_word(puc_pkg::ACT_LOAD_LAST, 1023, 345);
    queue_word(puc_pkg::ACT_MEASURE, 0, 512);
    queue_word(puc_pkg::ACT_LOAD_LAST, 0, 1023);
    queue_word(puc_pkg::ACT_MEASURE, 1023, 0);
    queue_word(puc_pkg::ACT_CALIBRATE, 300, 700);
    queue_word(puc_pkg::ACT_MEASURE, 300, 700);
    queue_word(puc_pkg::ACT_MEASURE, 1023, 1023);
    queue_word(puc_pkg::ACT_MEASURE, 0, 0);
    queue_word(ACT_UNUSED, 1023, 1023);
    queue_word(puc_pkg::ACT_MEASURE, 20, 600);
    queue_word(puc_pkg::ACT_CALIBRATE, 0, 0);
    queue_word(puc_pkg::ACT_MEASURE, 1023, 0);
    queue_word(puc_pkg::ACT_LOAD_LAST, 511, 0);
    queue_word(puc_pkg::ACT_MEASURE, 1000, 1000);
    queue_word(puc_pkg::ACT_MEASURE, 0, 1023);
    queue_word(puc_pkg::ACT_CALIBRATE, 1023, 1023);
    queue_word(puc_pkg::ACT_MEASURE, 512, 512);
    queue_word(ACT_UNUSED, 0, 0);
    drain();

    // Random phases, each under its own coefficient setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       write_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        1:       write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        2:       write_all(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        3:       write_all(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        4:       write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (int i = 0; i < PhaseWords; i++) begin
        // Mostly a slowly drifting pressure that wraps, sometimes a jump
        r = $urandom_range(0, 99);
        act = (r < 60) ? puc_pkg::ACT_MEASURE : (r < 75) ? puc_pkg::ACT_CALIBRATE :
              (r < 88) ? puc_pkg::ACT_LOAD_LAST : ACT_UNUSED;
        if ($urandom_range(0, 7) == 0) walk = $urandom_range(0, 1022);
        else walk = (walk + $urandom_range(0, 80) - 40 + 1023) % 1023;
        rp = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : walk;
        rt = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? 1023 : 0)
                                         : $urandom_range(0, 1023);
        queue_word(act[puc_pkg::ActW-1:0], rp, rt);
      end
      drain();
    end

    $display("covered %0d words under %0d coefficient settings, %0d results checked",
             words_in, NumPhases + 1, words_out);
    $display("%0d calibrations, %0d offset-corrected readings, %0d long hold-offs",
             calibrations, corrected, squeezes);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
